>>> design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared command codes, timing constants and the queued item type for the
// I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam int unsigned CmdW = 3;

  localparam logic [CmdW-1:0] CMD_IDLE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_START = 3'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ  = 3'd4;

  localparam int unsigned PhaseW = 5;

  // Last phase of each command; start and stop share one.
  localparam logic [PhaseW-1:0] LAST_SHORT = 5'd3;
  localparam logic [PhaseW-1:0] LAST_WRITE = 5'd17;
  localparam logic [PhaseW-1:0] LAST_READ  = 5'd18;
  // First phase past the eight data bits.
  localparam logic [PhaseW-1:0] DATA_END   = 5'd16;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [7:0]      tx_byte;
    logic            ack_flag;
    logic            sda_in;
  } tick_t;

endpackage

`default_nettype wire

>>> design/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts tick items, folds the action into a command code and holds them
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          action_i,
  input  wire logic [7:0]          tx_byte_i,
  input  wire logic                ack_flag_i,
  input  wire logic                sda_in_i,
  output logic                     q_valid_o,
  output i2cms_pkg::tick_t         q_item_o,
  input  wire logic                q_pop_i
);

  i2cms_pkg::tick_t                 entry_q [i2cms_pkg::QDepth];
  i2cms_pkg::tick_t                 item;
  logic [i2cms_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [i2cms_pkg::QCntW-1:0]      count_q, count_d;
  logic                             push, pop;

  // Undefined action codes are plain ticks, just like action 0.
  always_comb begin
    item.tx_byte  = tx_byte_i;
    item.ack_flag = ack_flag_i;
    item.sda_in   = sda_in_i;
    case (action_i)
      i2cms_pkg::CMD_START: item.cmd = i2cms_pkg::CMD_START;
      i2cms_pkg::CMD_STOP:  item.cmd = i2cms_pkg::CMD_STOP;
      i2cms_pkg::CMD_WRITE: item.cmd = i2cms_pkg::CMD_WRITE;
      i2cms_pkg::CMD_READ:  item.cmd = i2cms_pkg::CMD_READ;
      default:              item.cmd = i2cms_pkg::CMD_IDLE;
    endcase
  end

  assign in_stall_o = (count_q == i2cms_pkg::QCntW'(i2cms_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

>>> design/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back
// Runs the start, stop, write and read sequences one tick per queued item
// and holds each tick's line levels in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire i2cms_pkg::tick_t    q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     scl_level_o,
  output logic                     sda_level_o,
  output logic                     busy_res_o,
  output logic                     done_res_o,
  output logic [7:0]               rx_byte_o
);

  logic [i2cms_pkg::PhaseW-1:0] phase_q, phase_d, p, last_p;
  logic [i2cms_pkg::CmdW-1:0]   cmd_q, cmd_d, cur_cmd;
  logic [7:0]                   shift_q, shift_d, shift_base;
  logic                         scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic                         start_new, ack_cur, take;
  logic                         scl, sda, busy, done;
  logic [7:0]                   rx;
  logic [2:0]                   bit_idx;

  logic                         out_valid_q;
  logic                         out_scl_q, out_sda_q, out_busy_q, out_done_q;
  logic [7:0]                   out_rx_q;

  assign take    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = take;

  assign start_new = (cmd_q == i2cms_pkg::CMD_IDLE) && (q_item_i.cmd != i2cms_pkg::CMD_IDLE);
  assign cur_cmd   = (cmd_q == i2cms_pkg::CMD_IDLE) ? q_item_i.cmd : cmd_q;
  assign p         = start_new ? '0 : phase_q;
  assign ack_cur   = (start_new && q_item_i.cmd == i2cms_pkg::CMD_READ) ? q_item_i.ack_flag
                                                                        : ack_q;
  // Data bits go out MSB first, two phases per bit.
  assign bit_idx   = 3'd7 - p[3:1];

  always_comb begin
    shift_base = shift_q;
    if (start_new && q_item_i.cmd == i2cms_pkg::CMD_WRITE) begin
      shift_base = q_item_i.tx_byte;
    end else if (start_new && q_item_i.cmd == i2cms_pkg::CMD_READ) begin
      shift_base = '0;
    end
  end

  always_comb begin
    scl     = scl_q;
    sda     = sda_q;
    shift_d = shift_base;
    busy    = 1'b1;
    last_p  = i2cms_pkg::LAST_SHORT;
    case (cur_cmd)
      i2cms_pkg::CMD_START: begin
        case (p)
          5'd0:    sda = 1'b1;
          5'd1:    begin scl = 1'b1; sda = 1'b1; end
          5'd2:    begin scl = 1'b1; sda = 1'b0; end
          default: begin scl = 1'b0; sda = 1'b0; end
        endcase
      end
      i2cms_pkg::CMD_STOP: begin
        case (p)
          5'd0:    scl = 1'b0;
          5'd1:    begin scl = 1'b0; sda = 1'b0; end
          5'd2:    begin scl = 1'b1; sda = 1'b0; end
          default: begin scl = 1'b1; sda = 1'b1; end
        endcase
      end
      i2cms_pkg::CMD_WRITE: begin
        last_p = i2cms_pkg::LAST_WRITE;
        if (p < i2cms_pkg::DATA_END) begin
          sda = shift_base[bit_idx];
          if (p[0]) begin
            scl = 1'b1;
          end else if (p != '0) begin
            scl = 1'b0;
          end
        end else begin
          // Acknowledge slot is clocked with SDA released and not sampled.
          sda = 1'b1;
          scl = (p != i2cms_pkg::DATA_END);
        end
      end
      i2cms_pkg::CMD_READ: begin
        last_p = i2cms_pkg::LAST_READ;
        if (p < i2cms_pkg::DATA_END) begin
          sda = 1'b1;
          if (!p[0]) begin
            scl     = 1'b1;
            shift_d = {shift_base[6:0], q_item_i.sda_in};
          end else begin
            scl = 1'b0;
          end
        end else begin
          sda = !ack_cur;
          scl = (p == i2cms_pkg::LAST_WRITE);
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign done = busy && (p >= last_p);
  assign rx   = (done && cur_cmd == i2cms_pkg::CMD_READ) ? shift_d : '0;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_cur;
    if (busy) begin
      scl_d = scl;
      sda_d = sda;
      if (done) begin
        cmd_d   = i2cms_pkg::CMD_IDLE;
        phase_d = '0;
        if (cur_cmd == i2cms_pkg::CMD_WRITE) begin
          scl_d = 1'b0;
        end
        if (cur_cmd == i2cms_pkg::CMD_READ) begin
          sda_d = 1'b1;
        end
      end else begin
        cmd_d   = cur_cmd;
        phase_d = p + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      cmd_q       <= i2cms_pkg::CMD_IDLE;
      shift_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        shift_q <= shift_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_scl_q  <= scl;
      out_sda_q  <= sda;
      out_busy_q <= busy;
      out_done_q <= done;
      out_rx_q   <= rx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = out_scl_q;
  assign sda_level_o = out_sda_q;
  assign busy_res_o  = out_busy_q;
  assign done_res_o  = out_done_q;
  assign rx_byte_o   = out_rx_q;

  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == i2cms_pkg::CMD_IDLE |-> phase_q == '0)
    else $error("phase counter not cleared while idle");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= i2cms_pkg::LAST_READ)
    else $error("phase counter beyond the longest command");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_busy_q)
    else $error("done flagged on an idle tick");

  a_rx_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_done_q |-> out_rx_q == '0)
    else $error("received byte shown outside the last tick of a read");

endmodule

`default_nettype wire

>>> design/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master line sequencer: one result item of SCL/SDA levels per tick item.
// ----------------------------------------------------------------------------
// Each input item is one delay tick from a prescaler. While the sequencer is
// idle, the tick's action may start a start (4 ticks), stop (4 ticks), byte
// write (18 ticks) or byte read (19 ticks); actions arriving while busy are
// ignored. Every accepted item yields exactly one result item carrying the
// SCL and SDA levels for that tick (1 = released), busy, done on the last
// tick of a command, and the received byte on the done tick of a read.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. One item per clock is sustained while the receiver does not stall:
// the two-entry front queue takes a new item while handing on the oldest,
// and the sequencer state updates on every item it takes. A result item turns
// valid in the output register once the sequencer has taken its input item.
// When the receiver stalls, the output register holds its item and the front
// queue keeps accepting until both of its entries are full, then stalls the
// sender. Reset empties the queue and output register, leaves the sequencer
// idle and both lines released.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       ack_flag_i,
  input  wire logic       sda_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rx_byte_o
);

  logic             q_valid, q_pop;
  i2cms_pkg::tick_t q_item;

  i2cms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .tx_byte_i  (tx_byte_i),
    .ack_flag_i (ack_flag_i),
    .sda_in_i   (sda_in_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer
// Self-checking bench for the I2C master bit sequencer. A short table of
// directed ticks covers the idle codes, ignored commands while busy, every
// command and the all-ones byte. Random tick streams follow. Every
// result item is compared field by field with a line-level model of the
// sequencer or, for typed table rows, with the row's fixed levels. Both
// handshakes see random gaps and stalls.

module tb_i2c_master_bit_sequencer;

  // Action codes that fall outside the command set and only make idle ticks.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_TICKS = 1000;
  localparam int unsigned IDLE_PCT     = 38;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
  } line_result_t;

  typedef struct packed {
    logic [2:0]   action;
    logic [7:0]   tx;
    logic         ack;
    logic         sda;
    logic [4:0]   reps;
    logic         typed;
    line_result_t want;
  } tick_row_t;

  localparam line_result_t LINES_IDLE_HIGH = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam line_result_t LINES_READ_FF   = {1'b0, 1'b0, 1'b1, 1'b1, 8'hFF};
  localparam line_result_t LINES_STOP_DONE = {1'b1, 1'b1, 1'b1, 1'b1, 8'h00};
  localparam line_result_t LINES_NONE      = '0;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] action_i;
  logic [7:0] tx_byte_i;
  logic       ack_flag_i;
  logic       sda_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;

  i2c_master_bit_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .tx_byte_i   (tx_byte_i),
    .ack_flag_i  (ack_flag_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o)
  );

  // Model state of the sequencer.
  logic [4:0]   model_phase;
  logic [2:0]   model_cmd;
  logic [7:0]   model_shift;
  logic         model_scl;
  logic         model_sda;
  logic         model_ack;

  line_result_t pending_lines[$];
  tick_row_t    tick_table[$];
  int unsigned  error_count;
  int unsigned  ticks_checked;
  int unsigned  starts_run, stops_run, writes_run, reads_run;
  bit           no_idle;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic tick_row_t make_row(logic [2:0] action, logic [7:0] tx, logic ack,
                                         logic sda, logic [4:0] reps, logic typed,
                                         line_result_t want);
    tick_row_t row;
    row.action = action;
    row.tx     = tx;
    row.ack    = ack;
    row.sda    = sda;
    row.reps   = reps;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  // Advances the model by one tick and returns the line levels it produces.
  function automatic line_result_t predict_tick(logic [2:0] action, logic [7:0] tx,
                                                logic ack, logic sdai);
    line_result_t res;
    logic [4:0]   p;
    logic [4:0]   last;
    res = '0;
    if (model_cmd == i2cms_pkg::CMD_IDLE) begin
      if (action >= i2cms_pkg::CMD_START && action <= i2cms_pkg::CMD_READ) begin
        model_cmd   = action;
        model_phase = '0;
        case (action)
          i2cms_pkg::CMD_START: starts_run++;
          i2cms_pkg::CMD_STOP:  stops_run++;
          i2cms_pkg::CMD_WRITE: begin
            writes_run++;
            model_shift = tx;
          end
          default: begin
            reads_run++;
            model_shift = '0;
            model_ack   = ack;
          end
        endcase
      end else begin
        res.scl = model_scl;
        res.sda = model_sda;
        return res;
      end
    end

    p        = model_phase;
    res.scl  = model_scl;
    res.sda  = model_sda;
    res.busy = 1'b1;

    case (model_cmd)
      i2cms_pkg::CMD_START: begin
        if (p == 5'd0) begin
          res.sda = 1'b1;
        end else if (p == 5'd1) begin
          res.scl = 1'b1;
          res.sda = 1'b1;
        end else if (p == 5'd2) begin
          res.scl = 1'b1;
          res.sda = 1'b0;
        end else begin
          res.scl = 1'b0;
          res.sda = 1'b0;
        end
      end
      i2cms_pkg::CMD_STOP: begin
        if (p == 5'd0) begin
          res.scl = 1'b0;
        end else if (p == 5'd1) begin
          res.scl = 1'b0;
          res.sda = 1'b0;
        end else if (p == 5'd2) begin
          res.scl = 1'b1;
          res.sda = 1'b0;
        end else begin
          res.scl = 1'b1;
          res.sda = 1'b1;
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        if (p < i2cms_pkg::DATA_END) begin
          res.sda = model_shift[3'd7 - p[3:1]];
          if (p[0]) begin
            res.scl = 1'b1;
          end else if (p != 5'd0) begin
            res.scl = 1'b0;
          end
        end else begin
          res.sda = 1'b1;
          res.scl = (p == i2cms_pkg::DATA_END) ? 1'b0 : 1'b1;
        end
      end
      default: begin
        if (p < i2cms_pkg::DATA_END) begin
          res.sda = 1'b1;
          if (!p[0]) begin
            res.scl     = 1'b1;
            model_shift = {model_shift[6:0], sdai};
          end else begin
            res.scl = 1'b0;
          end
        end else begin
          res.sda = !model_ack;
          res.scl = (p == i2cms_pkg::DATA_END + 5'd1);
        end
      end
    endcase

    model_scl = res.scl;
    model_sda = res.sda;

    if (model_cmd == i2cms_pkg::CMD_WRITE) begin
      last = i2cms_pkg::LAST_WRITE;
    end else if (model_cmd == i2cms_pkg::CMD_READ) begin
      last = i2cms_pkg::LAST_READ;
    end else begin
      last = i2cms_pkg::LAST_SHORT;
    end

    if (p >= last) begin
      res.done = 1'b1;
      // A write leaves SCL held low; a read lets SDA go after its acknowledge.
      if (model_cmd == i2cms_pkg::CMD_WRITE) begin
        model_scl = 1'b0;
      end
      if (model_cmd == i2cms_pkg::CMD_READ) begin
        model_sda = 1'b1;
        res.rx    = model_shift;
      end
      model_cmd   = i2cms_pkg::CMD_IDLE;
      model_phase = '0;
    end else begin
      model_phase = p + 5'd1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("MISMATCH %s: expected %0h, got %0h (result item %0d)",
             what, want, got, ticks_checked);
    error_count++;
  endtask

  // Offers one tick item, starting and ending at a falling edge.
  task automatic send_tick(logic [2:0] action, logic [7:0] tx, logic ack, logic sdai,
                           logic typed, line_result_t want);
    line_result_t predicted;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i   <= action;
    tx_byte_i  <= tx;
    ack_flag_i <= ack;
    sda_in_i   <= sdai;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predicted = predict_tick(action, tx, ack, sdai);
    pending_lines.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lines.size() == 0) begin
        report_mismatch("result item with nothing pending", 0,
                        {scl_level_o, sda_level_o, busy_res_o, done_res_o, rx_byte_o});
      end else begin
        want = pending_lines.pop_front();
        if (scl_level_o !== want.scl) report_mismatch("scl_level", want.scl, scl_level_o);
        if (sda_level_o !== want.sda) report_mismatch("sda_level", want.sda, sda_level_o);
        if (busy_res_o !== want.busy) report_mismatch("busy_res", want.busy, busy_res_o);
        if (done_res_o !== want.done) report_mismatch("done_res", want.done, done_res_o);
        if (rx_byte_o !== want.rx) report_mismatch("rx_byte", want.rx, rx_byte_o);
      end
      ticks_checked++;
    end
  end

  // Far beyond the slowest legal run, including the longest random gaps.
  initial begin
    #2000000;
    $display("Timeout: %0d result items still pending", pending_lines.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [2:0] action;
    int unsigned pick;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    action_i    = i2cms_pkg::CMD_IDLE;
    tx_byte_i   = '0;
    ack_flag_i  = 1'b0;
    sda_in_i    = 1'b0;
    no_idle     = 1'b0;
    error_count = 0;
    ticks_checked = 0;
    starts_run  = 0;
    stops_run   = 0;
    writes_run  = 0;
    reads_run   = 0;
    model_phase = '0;
    model_cmd   = i2cms_pkg::CMD_IDLE;
    model_shift = '0;
    model_scl   = 1'b1;
    model_sda   = 1'b1;
    model_ack   = 1'b0;

    // Idle codes, a start with commands ignored while busy, an all-ones write
    // with writes ignored, an all-ones read with ACK, then a stop.
    tick_table.push_back(make_row(i2cms_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b0, 5'd1, 1'b1,
                                  LINES_IDLE_HIGH));
    tick_table.push_back(make_row(ACT_SPARE_LO, 8'hFF, 1'b1, 1'b1, 5'd1, 1'b1,
                                  LINES_IDLE_HIGH));
    tick_table.push_back(make_row(ACT_SPARE_HI, 8'h00, 1'b0, 1'b1, 5'd1, 1'b1,
                                  LINES_IDLE_HIGH));
    tick_table.push_back(make_row(i2cms_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 5'd1, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 5'd3, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0, 5'd1, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0, 5'd17, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_READ, 8'h00, 1'b1, 1'b1, 5'd1, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_READ, 8'h00, 1'b0, 1'b1, 5'd17, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b1, 5'd1, 1'b1,
                                  LINES_READ_FF));
    tick_table.push_back(make_row(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 5'd1, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b0, 5'd2, 1'b0,
                                  LINES_NONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b0, 5'd1, 1'b1,
                                  LINES_STOP_DONE));
    tick_table.push_back(make_row(i2cms_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b0, 5'd1, 1'b1,
                                  LINES_IDLE_HIGH));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (tick_table[i]) begin
      repeat (tick_table[i].reps) begin
        send_tick(tick_table[i].action, tick_table[i].tx, tick_table[i].ack,
                  tick_table[i].sda, tick_table[i].typed, tick_table[i].want);
      end
    end

    for (int n = 0; n < RANDOM_TICKS; n++) begin
      // Hold the sender off once until every pending result item has drained.
      if (n == 300) begin
        in_valid_i <= 1'b0;
        do begin
          @(negedge clk_i);
        end while (pending_lines.size() != 0);
      end
      no_idle = (n >= 500 && n < 700);
      pick = $urandom_range(99);
      if (pick < 30) begin
        action = 3'($urandom_range(i2cms_pkg::CMD_READ, i2cms_pkg::CMD_START));
      end else if (pick < 36) begin
        action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      end else begin
        action = i2cms_pkg::CMD_IDLE;
      end
      send_tick(action, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, LINES_NONE);
    end

    in_valid_i <= 1'b0;
    while (pending_lines.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);

    $display("Checked %0d result items from %0d starts, %0d stops, %0d writes, %0d reads",
             ticks_checked, starts_run, stops_run, writes_run, reads_run);
    $display("with ignored commands, spare codes and random sender and receiver gaps.");
    if (error_count == 0 && pending_lines.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/i2cms_pkg.sv
design/i2cms_front.sv
design/i2cms_back.sv
design/i2c_master_bit_sequencer.sv
verif/tb_i2c_master_bit_sequencer.sv
